// File: rtl/ppid_pkg.sv
// Package for the positional PID controller with integral clamp.
// Holds the register map, reset values and fixed field widths.
// No dependencies; imported by the controller top level.
package ppid_pkg;

	// Fixed field widths
	localparam int GAIN_W  = 16;
	localparam int LIMIT_W = 31;
	localparam int INTEG_W = 32;
	localparam int OUT_W   = 32;

	// Configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes (byte address is 4 * index)
	typedef enum logic [1:0] {
		REG_PROP_GAIN   = 2'd0,
		REG_INTEG_GAIN  = 2'd1,
		REG_DERIV_GAIN  = 2'd2,
		REG_INTEG_LIMIT = 2'd3
	} reg_idx_t;

	// Register reset values
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd568;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd201;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd306;
	localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 31'd1000;

	// Signed 32-bit range
	localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

endpackage

// File: rtl/positional_pid_with_integral_clamp.sv
// Positional PID controller with clamped error integral, Q gains.
// Five-stage pipeline with a register-mapped configuration port.
// Depends on ppid_pkg for the register map and fixed widths.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one sample beat: a target
//   and a measured value. Output channel (out_valid / out_stall) carries one
//   control_out beat per sample, in order.
//   A sample taken into stage 1 passes stages 2 to 4 and the output register
//   before it shows on control_out. Throughput: one sample per cycle while
//   out_stall is low; the integral and previous-error update closes in stage 1.
//   Stall: each stage holds only while it is full and the stage after it is
//   blocked, so a waiting result does not stop new samples until every stage
//   is occupied; in_stall then rises.
//   Reset: arst_n clears the integral, the previous error and all stage
//   valids, and loads the gain and limit registers with their defaults.
//   Configuration: APB writes at byte address 4*index, pready always high;
//   write only while no sample is in flight.
module positional_pid_with_integral_clamp
	import ppid_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Sample channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] target_value,
	input  logic signed [SAMPLE_WIDTH-1:0] measured_value,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [OUT_W-1:0]        control_out,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ADDR_W-1:0]              paddr,
	input  logic [DATA_W-1:0]              pwdata,
	output logic [DATA_W-1:0]              prdata,
	output logic                           pready
);

	// Derived widths
	localparam int ERR_W = SAMPLE_WIDTH + 1;
	localparam int DER_W = ERR_W + 1;
	localparam int SUM_W = INTEG_W + 1;
	localparam int PP_W  = ERR_W + GAIN_W + 1;
	localparam int PI_W  = INTEG_W + GAIN_W + 1;
	localparam int PD_W  = DER_W + GAIN_W + 1;
	localparam int ACC_W = ((PD_W > PI_W) ? PD_W : PI_W) + 2;
	localparam logic [ACC_W-1:0] ROUND_BIAS =
		ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

	// Configuration registers
	logic [GAIN_W-1:0]  prop_gain_q;
	logic [GAIN_W-1:0]  integ_gain_q;
	logic [GAIN_W-1:0]  deriv_gain_q;
	logic [LIMIT_W-1:0] integ_limit_q;

	// Controller state
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_err_q;

	// Pipeline registers
	logic                           valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] tgt_s1, meas_s1;
	logic signed [ERR_W-1:0]        err_s2;
	logic signed [INTEG_W-1:0]      integ_s2;
	logic signed [DER_W-1:0]        deriv_s2;
	logic signed [PP_W-1:0]         pp_s3;
	logic signed [PI_W-1:0]         pi_s3;
	logic signed [PD_W-1:0]         pd_s3;
	logic signed [ACC_W-1:0]        acc_s4;
	logic signed [OUT_W-1:0]        ctl_q;

	// Combinational stage logic
	logic                      ready_s1, ready_s2, ready_s3, ready_s4, ready_out;
	logic                      fire_s1;
	logic signed [ERR_W-1:0]   err;
	logic signed [SUM_W-1:0]   integ_sum, integ_hi, integ_lo;
	logic signed [INTEG_W-1:0] integ_next;
	logic signed [DER_W-1:0]   deriv;
	logic signed [ACC_W-1:0]   acc_rnd, acc_quo;
	logic signed [OUT_W-1:0]   ctl_next;
	logic                      cfg_wr;
	reg_idx_t                  cfg_idx;

	// Configuration write and read
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			integ_limit_q <= INTEG_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PROP_GAIN:   prop_gain_q   <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:  integ_gain_q  <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:  deriv_gain_q  <= pwdata[GAIN_W-1:0];
				REG_INTEG_LIMIT: integ_limit_q <= pwdata[LIMIT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PROP_GAIN:   prdata = DATA_W'(prop_gain_q);
			REG_INTEG_GAIN:  prdata = DATA_W'(integ_gain_q);
			REG_DERIV_GAIN:  prdata = DATA_W'(deriv_gain_q);
			REG_INTEG_LIMIT: prdata = DATA_W'(integ_limit_q);
		endcase
	end

	// Stage flow: a stage takes a beat when empty or when it is passing one on
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s4  = !valid_s4 || ready_out;
	assign ready_s3  = !valid_s3 || ready_s4;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign fire_s1   = valid_s1 && ready_s2;
	assign in_stall  = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)  valid_s1    <= in_valid;
			if (ready_s2)  valid_s2    <= valid_s1;
			if (ready_s3)  valid_s3    <= valid_s2;
			if (ready_s4)  valid_s4    <= valid_s3;
			if (ready_out) out_valid_q <= valid_s4;
		end
	end

	// Stage 1: error, clamped integral and derivative
	always_comb begin
		err       = ERR_W'(tgt_s1) - ERR_W'(meas_s1);
		integ_sum = SUM_W'(integ_q) + SUM_W'(err);
		if (integ_limit_q != '0) begin
			integ_hi = $signed({2'b00, integ_limit_q});
			integ_lo = -$signed({2'b00, integ_limit_q});
		end else begin
			integ_hi = SUM_W'(OUT_MAX);
			integ_lo = SUM_W'(OUT_MIN);
		end
		if (integ_sum > integ_hi) begin
			integ_next = INTEG_W'(integ_hi);
		end else if (integ_sum < integ_lo) begin
			integ_next = INTEG_W'(integ_lo);
		end else begin
			integ_next = INTEG_W'(integ_sum);
		end
		deriv = DER_W'(err) - DER_W'(prev_err_q);
	end

	// Update controller state once per sample leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
		end else if (fire_s1) begin
			integ_q    <= integ_next;
			prev_err_q <= err;
		end
	end

	// Datapath registers: load on each advancing beat
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			tgt_s1  <= target_value;
			meas_s1 <= measured_value;
		end
		if (fire_s1) begin
			err_s2   <= err;
			integ_s2 <= integ_next;
			deriv_s2 <= deriv;
		end
		// Stage 2: gain products
		if (valid_s2 && ready_s3) begin
			pp_s3 <= PP_W'($signed({1'b0, prop_gain_q})) * PP_W'(err_s2);
			pi_s3 <= PI_W'($signed({1'b0, integ_gain_q})) * PI_W'(integ_s2);
			pd_s3 <= PD_W'($signed({1'b0, deriv_gain_q})) * PD_W'(deriv_s2);
		end
		// Stage 3: sum of terms
		if (valid_s3 && ready_s4) begin
			acc_s4 <= ACC_W'(pp_s3) + ACC_W'(pi_s3) + ACC_W'(pd_s3);
		end
		// Stage 4: scale and saturate
		if (valid_s4 && ready_out) begin
			ctl_q <= ctl_next;
		end
	end

	// Drop the fraction toward zero, then saturate to 32 bits
	always_comb begin
		acc_rnd = acc_s4 + (acc_s4[ACC_W-1] ? $signed(ROUND_BIAS) : $signed(ACC_W'(0)));
		acc_quo = acc_rnd >>> GAIN_FRAC_BITS;
		if (acc_quo > ACC_W'(OUT_MAX)) begin
			ctl_next = OUT_MAX;
		end else if (acc_quo < ACC_W'(OUT_MIN)) begin
			ctl_next = OUT_MIN;
		end else begin
			ctl_next = OUT_W'(acc_quo);
		end
	end

	assign out_valid   = out_valid_q;
	assign control_out = ctl_q;

`ifndef NO_ASSERTIONS
	// Integral stays inside a nonzero limit after each update
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && integ_limit_q != '0) |=>
		(integ_q <= $signed({1'b0, $past(integ_limit_q)}) &&
		 integ_q >= -$signed({1'b0, $past(integ_limit_q)})))
		else $error("integral outside clamp limit");

	// Controller state moves only when a sample leaves stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> ($stable(integ_q) && $stable(prev_err_q)))
		else $error("controller state changed without a sample");

	// Input stalls only with every stage full and the output blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 &&
		              out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");
`endif

endmodule
